// ----- design/csine_pkg.sv -----
// ----------------------------------------------------------------------------
// csine_pkg
// Shared types, constants and the arctangent table for the CORDIC sine block.
// ----------------------------------------------------------------------------
package csine_pkg;

   localparam int ROTATION_STEPS_DEFAULT = 15;
   localparam int ANGLE_W = 32;
   localparam int SINE_W  = 18;
   localparam int SCALE_W = 17;
   localparam int ATAN_W  = 17;
   localparam int IDX_W   = 4;
   localparam int XY_W    = 20;
   localparam int PROD_W  = 38;
   localparam int TDATA_OUT_W = 24;
   localparam int WIDE_W      = 64;
   localparam int RECIP_SHIFT = 50;
   localparam int Q_W         = WIDE_W - RECIP_SHIFT;

   localparam logic [ANGLE_W-1:0] Q_TWO_PI  = 32'd411775;
   localparam logic [ANGLE_W-1:0] Q_PI      = 32'd205887;
   localparam logic [ANGLE_W-1:0] Q_HALF_PI = 32'd102944;
   // floor(2^50 / Q_TWO_PI); quotient estimate is exact or one low
   localparam logic [ANGLE_W-1:0] Q_RECIP   = 32'd2734259988;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 17'd39797;

   // reduction sub-steps, counted down
   localparam logic [IDX_W-1:0]   RED_MUL     = 4'd2;
   localparam logic [IDX_W-1:0]   RED_SUB     = 4'd1;
   localparam logic [IDX_W-1:0]   RED_FIX     = 4'd0;
   localparam logic [IDX_W-1:0]   REDUCE_TOP  = RED_MUL;
   localparam logic signed [XY_W-1:0] X_INIT  = 20'sd65536;

   localparam logic signed [SINE_W:0] SINE_MAX = 19'sd131071;
   localparam logic signed [SINE_W:0] SINE_MIN = -19'sd131072;

   typedef struct packed {
      logic             load;
      logic             reduce;
      logic             fold_pi;
      logic             fold_half;
      logic             rotate;
      logic             mult;
      logic             finish;
      logic [IDX_W-1:0] count;
   } dp_ctl_type;

   // atan(2^-i), Q1.16 rounded
   function automatic logic [ATAN_W-1:0] atan_entry(input logic [IDX_W-1:0] idx);
      logic [ATAN_W-1:0] val;
      case (idx)
         4'd0:    val = 17'd51472;
         4'd1:    val = 17'd30386;
         4'd2:    val = 17'd16055;
         4'd3:    val = 17'd8150;
         4'd4:    val = 17'd4091;
         4'd5:    val = 17'd2047;
         4'd6:    val = 17'd1024;
         4'd7:    val = 17'd512;
         4'd8:    val = 17'd256;
         4'd9:    val = 17'd128;
         4'd10:   val = 17'd64;
         4'd11:   val = 17'd32;
         4'd12:   val = 17'd16;
         4'd13:   val = 17'd8;
         4'd14:   val = 17'd4;
         4'd15:   val = 17'd2;
         default: val = 17'd0;
      endcase
      return val;
   endfunction

endpackage

// ----- design/cordic_fixed_sine.sv -----
// ----------------------------------------------------------------------------
// cordic_fixed_sine
// Sequence from input beat to rsp_tvalid: 3 reduction steps, 2 fold,
// one rotation step per cycle, multiply, then the result load, which waits
// while a previous sine beat still waits on rsp_tready.
// A new input beat is accepted only in idle, after the previous result load,
// as the single shared reduction/rotation datapath serves one item at a time.
// Reset: synchronous; clears sequencer and output valid, gain returns to 39797.
// ----------------------------------------------------------------------------
module cordic_fixed_sine
   import csine_pkg::*;
#(
   parameter int ROTATION_STEPS = ROTATION_STEPS_DEFAULT
)(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [ANGLE_W-1:0]     req_tdata,   // [31:0] angle
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [TDATA_OUT_W-1:0] rsp_tdata,   // [17:0] sine, [23:18] zero
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [2:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

   dp_ctl_type         ctl;
   logic [SCALE_W-1:0] scale;
   logic [SINE_W-1:0]  sine;

   csine_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .scale       (scale)
   );

   csine_ctrl #(
      .ROTATION_STEPS (ROTATION_STEPS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctl        (ctl)
   );

   csine_datapath u_dp (
      .clock (clock),
      .ctl   (ctl),
      .angle (req_tdata),
      .scale (scale),
      .sine  (sine)
   );

   assign rsp_tdata = {{(TDATA_OUT_W-SINE_W){1'b0}}, sine};

endmodule

// ----- design/csine_csr.sv -----
// ----------------------------------------------------------------------------
// csine_csr
// APB register slave holding the post-rotation gain.
// ----------------------------------------------------------------------------
module csine_csr
   import csine_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready,
   output logic [SCALE_W-1:0] scale
);

   logic [SCALE_W-1:0] scale_ff;
   logic [SCALE_W-1:0] scale_in;
   logic               wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite && !csr_paddr[2];

   always_comb begin
      scale_in = scale_ff;
      if (wr_en) begin
         scale_in = csr_pwdata[SCALE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else begin
         scale_ff <= scale_in;
      end
   end

   assign csr_prdata = csr_paddr[2] ? 32'd0 : {{(32-SCALE_W){1'b0}}, scale_ff};
   assign scale      = scale_ff;

endmodule

// ----- design/csine_datapath.sv -----
// ----------------------------------------------------------------------------
// csine_datapath
// Range reduction by reciprocal multiply, CORDIC rotation, gain multiply.
// ----------------------------------------------------------------------------
module csine_datapath
   import csine_pkg::*;
(
   input  logic                clock,
   input  dp_ctl_type          ctl,
   input  logic [ANGLE_W-1:0]  angle,
   input  logic [SCALE_W-1:0]  scale,
   output logic [SINE_W-1:0]   sine
);

   logic [ANGLE_W-1:0]       w_ff, w_in;
   logic [Q_W-1:0]           q_ff, q_in;
   logic                     neg_ff, neg_in;
   logic signed [XY_W-1:0]   x_ff, x_in;
   logic signed [XY_W-1:0]   y_ff, y_in;
   logic signed [XY_W-1:0]   acc_ff, acc_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [SINE_W-1:0]        sine_ff, sine_in;

   logic [WIDE_W-1:0]        recip_prod;
   logic [ANGLE_W-1:0]       q_times_d;
   logic signed [XY_W-1:0]   xs, ys, atan_s, tgt_s;
   logic                     forward;
   logic signed [SINE_W+4:0] scaled, signed_r;

   always_comb begin
      recip_prod = WIDE_W'(w_ff) * WIDE_W'(Q_RECIP);
      q_times_d  = ANGLE_W'(q_ff) * Q_TWO_PI;
      xs       = x_ff >>> ctl.count;
      ys       = y_ff >>> ctl.count;
      atan_s   = $signed({{(XY_W-ATAN_W){1'b0}}, atan_entry(ctl.count)});
      tgt_s    = $signed({3'b000, w_ff[XY_W-4:0]});
      forward  = acc_ff <= tgt_s;
      scaled   = $signed({prod_ff[PROD_W-1], prod_ff[PROD_W-1:16]});
      signed_r = neg_ff ? -scaled : scaled;

      w_in    = w_ff;
      q_in    = q_ff;
      neg_in  = neg_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      acc_in  = acc_ff;
      prod_in = prod_ff;
      sine_in = sine_ff;

      if (ctl.load) begin
         neg_in = angle[ANGLE_W-1];
         w_in   = angle[ANGLE_W-1] ? (32'd0 - angle) : angle;
         x_in   = X_INIT;
         y_in   = '0;
         acc_in = '0;
      end
      if (ctl.reduce) begin
         case (ctl.count)
            RED_MUL: begin
               q_in = recip_prod[WIDE_W-1:RECIP_SHIFT];
            end
            RED_SUB: begin
               w_in = w_ff - q_times_d;
            end
            RED_FIX: begin
               if (w_ff >= Q_TWO_PI) begin
                  w_in = w_ff - Q_TWO_PI;
               end
            end
            default: begin
               w_in = w_ff;
            end
         endcase
      end
      if (ctl.fold_pi && (w_ff > Q_PI)) begin
         neg_in = !neg_ff;
         w_in   = w_ff - Q_PI;
      end
      if (ctl.fold_half && (w_ff > Q_HALF_PI)) begin
         w_in = Q_PI - w_ff;
      end
      if (ctl.rotate) begin
         if (forward) begin
            acc_in = acc_ff + atan_s;
            x_in   = x_ff - ys;
            y_in   = y_ff + xs;
         end else begin
            acc_in = acc_ff - atan_s;
            x_in   = x_ff + ys;
            y_in   = y_ff - xs;
         end
      end
      if (ctl.mult) begin
         prod_in = PROD_W'(y_ff) * PROD_W'($signed({1'b0, scale}));
      end
      if (ctl.finish) begin
         if (signed_r > SINE_MAX) begin
            sine_in = SINE_MAX[SINE_W-1:0];
         end else if (signed_r < SINE_MIN) begin
            sine_in = SINE_MIN[SINE_W-1:0];
         end else begin
            sine_in = signed_r[SINE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      w_ff    <= w_in;
      q_ff    <= q_in;
      neg_ff  <= neg_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      sine_ff <= sine_in;
   end

   assign sine = sine_ff;

endmodule

// ----- design/csine_ctrl.sv -----
// ----------------------------------------------------------------------------
// csine_ctrl
// Sequencer: reduction, fold, rotation steps, multiply, result beat.
// ----------------------------------------------------------------------------
module csine_ctrl
   import csine_pkg::*;
#(
   parameter int ROTATION_STEPS = ROTATION_STEPS_DEFAULT
)(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output dp_ctl_type ctl
);

   typedef enum logic [6:0] {
      ST_IDLE      = 7'b0000001,
      ST_REDUCE    = 7'b0000010,
      ST_FOLD_PI   = 7'b0000100,
      ST_FOLD_HALF = 7'b0001000,
      ST_ROTATE    = 7'b0010000,
      ST_MULT      = 7'b0100000,
      ST_DONE      = 7'b1000000
   } state_type;

   localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(ROTATION_STEPS - 1);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] count_ff, count_in;
   logic             valid_ff, valid_in;
   logic             out_free, req_acc;

   assign out_free   = !valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = ST_REDUCE;
               count_in = REDUCE_TOP;
            end
         end
         ST_REDUCE: begin
            if (count_ff == '0) begin
               state_in = ST_FOLD_PI;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         ST_FOLD_PI:   state_in = ST_FOLD_HALF;
         ST_FOLD_HALF: begin
            state_in = ST_ROTATE;
            count_in = '0;
         end
         ST_ROTATE: begin
            if (count_ff == LAST_STEP) begin
               state_in = ST_MULT;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         ST_MULT: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl.load      = req_acc;
      ctl.reduce    = (state_ff == ST_REDUCE);
      ctl.fold_pi   = (state_ff == ST_FOLD_PI);
      ctl.fold_half = (state_ff == ST_FOLD_HALF);
      ctl.rotate    = (state_ff == ST_ROTATE);
      ctl.mult      = (state_ff == ST_MULT);
      ctl.finish    = (state_ff == ST_DONE) && out_free;
      ctl.count     = count_ff;
   end

   always_comb begin
      valid_in = valid_ff;
      if (ctl.finish) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;

   a_start_reduce: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (state_ff == ST_REDUCE) && (count_ff == REDUCE_TOP))
      else $error("accepted beat did not start range reduction");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROTATE) |-> (count_ff <= LAST_STEP))
      else $error("rotation step index out of range");

   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      ctl.finish |=> valid_ff && (state_ff == ST_IDLE))
      else $error("finished item did not present a result beat");

   a_mult_after_rot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MULT) |-> $past(state_ff == ST_ROTATE) && $past(count_ff) == LAST_STEP)
      else $error("multiply entered before last rotation step");

endmodule
